// File: hw/rtl/nis_pkg.sv
// Package for the note interval search block: constants, codes and shared types.
`default_nettype none

package nis_pkg;

    localparam int NOTE_DEPTH_DEFAULT = 1024;
    localparam int FRAME_BITS_DEFAULT = 32;

    localparam int INDEX_BITS     = 10;
    localparam int PITCH_BITS     = 7;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_INDEX = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_INDEX  = 2'd1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        STAT_PITCH = 2'd0,
        STAT_REST  = 2'd1,
        STAT_NONE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } state_t;

    typedef struct packed {
        status_t                status;
        logic [PITCH_BITS-1:0]  pitch;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/nis_if.sv
// Valid/ready channel interfaces for the request and result streams.
`default_nettype none

interface nis_req_if #(
    parameter int FRAME_BITS = nis_pkg::FRAME_BITS_DEFAULT
);
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [nis_pkg::INDEX_BITS-1:0]  entry_index;
    logic [FRAME_BITS-1:0]           entry_start_frame;
    logic [nis_pkg::PITCH_BITS-1:0]  entry_pitch;
    logic                            entry_is_rest;
    logic [FRAME_BITS-1:0]           search_frame;

    modport source (
        output valid, command, entry_index, entry_start_frame, entry_pitch,
               entry_is_rest, search_frame,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_start_frame, entry_pitch,
               entry_is_rest, search_frame,
        output ready
    );
endinterface

interface nis_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [nis_pkg::PITCH_BITS-1:0]  pitch;

    modport source (
        output valid, status, pitch,
        input  ready
    );
    modport sink (
        input  valid, status, pitch,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/nis_note_mem.sv
// Note table RAM: one write port, two registered read ports.
`default_nettype none

module nis_note_mem #(
    parameter int DEPTH = nis_pkg::NOTE_DEPTH_DEFAULT,
    parameter int WIDTH = nis_pkg::FRAME_BITS_DEFAULT + 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/nis_search_ctrl.sv
// Search sequencer: config registers, bound registers, probe compare and result register.
`default_nettype none

module nis_search_ctrl #(
    parameter int NOTE_DEPTH = nis_pkg::NOTE_DEPTH_DEFAULT,
    parameter int FRAME_BITS = nis_pkg::FRAME_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [nis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [nis_pkg::INDEX_BITS-1:0]      cfg_data,
    nis_req_if.sink                                  request,
    nis_rsp_if.source                                result,
    output logic                                     mem_we,
    output logic [$clog2(NOTE_DEPTH)-1:0]            mem_waddr,
    output logic [FRAME_BITS+7:0]                    mem_wdata,
    output logic                                     mem_re,
    output logic [$clog2(NOTE_DEPTH)-1:0]            mem_raddr_a,
    output logic [$clog2(NOTE_DEPTH)-1:0]            mem_raddr_b,
    input  wire logic [FRAME_BITS+7:0]               mem_rdata_a,
    input  wire logic [FRAME_BITS+7:0]               mem_rdata_b
);
    import nis_pkg::*;

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int WW = FRAME_BITS + 8;

    state_t                  state_reg, state_next;
    logic [INDEX_BITS-1:0]   first_reg, first_next;
    logic [INDEX_BITS-1:0]   last_reg, last_next;
    logic [INDEX_BITS-1:0]   lo_reg, lo_next;
    logic [INDEX_BITS-1:0]   hi_reg, hi_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic                    ok_a_reg, ok_a_next;
    logic                    ok_b_reg, ok_b_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_data_reg, out_data_next;

    logic [INDEX_BITS:0]     mid_sum;
    logic [INDEX_BITS-1:0]   mid;
    logic [INDEX_BITS:0]     mid_inc;
    logic                    accept;
    logic                    out_free;
    logic [FRAME_BITS-1:0]   start_a;
    logic [FRAME_BITS-1:0]   start_b;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[INDEX_BITS:1];
    assign mid_inc  = {1'b0, mid} + {{INDEX_BITS{1'b0}}, 1'b1};
    assign accept   = request.valid && request.ready;
    assign out_free = !out_valid_reg || result.ready;

    // entries outside the table read as start 0
    assign start_a = ok_a_reg ? mem_rdata_a[WW-1 -: FRAME_BITS] : '0;
    assign start_b = ok_b_reg ? mem_rdata_b[WW-1 -: FRAME_BITS] : '0;

    assign request.ready = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = out_data_reg.status;
    assign result.pitch  = out_data_reg.pitch;

    assign mem_we      = accept && (request.command == CMD_LOAD)
                         && (32'(request.entry_index) < NOTE_DEPTH);
    assign mem_waddr   = AW'(request.entry_index);
    assign mem_wdata   = {request.entry_start_frame, request.entry_pitch,
                          request.entry_is_rest};
    assign mem_raddr_a = AW'(mid);
    assign mem_raddr_b = AW'(mid_inc);

    always_comb
    begin
        first_next = first_reg;
        last_next  = last_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_INDEX: first_next = cfg_data;
                CFG_LAST_INDEX:  last_next  = cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        frame_next     = frame_reg;
        ok_a_next      = ok_a_reg;
        ok_b_next      = ok_b_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.command == CMD_SEARCH))
                begin
                    lo_next    = first_reg;
                    hi_next    = last_reg;
                    frame_next = request.search_frame;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next       = 1'b1;
                        out_data_next.status = STAT_NONE;
                        out_data_next.pitch  = '0;
                        state_next           = ST_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    ok_a_next  = (32'(mid) < NOTE_DEPTH);
                    ok_b_next  = (32'(mid_inc) < NOTE_DEPTH);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (start_a > frame_reg)
                begin
                    hi_next    = mid;
                    state_next = ST_PROBE;
                end
                else if (start_b > frame_reg)
                begin
                    // hold here until the result slot frees; read data stays put
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (ok_a_reg && mem_rdata_a[0])
                        begin
                            out_data_next.status = STAT_REST;
                            out_data_next.pitch  = '0;
                        end
                        else
                        begin
                            out_data_next.status = STAT_PITCH;
                            out_data_next.pitch  = ok_a_reg ? mem_rdata_a[PITCH_BITS:1] : '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    lo_next    = mid_inc[INDEX_BITS-1:0];
                    state_next = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        frame_reg    <= frame_next;
        ok_a_reg     <= ok_a_next;
        ok_b_reg     <= ok_b_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/note_interval_search.sv
// Note interval search top level: note table RAM plus binary search sequencer.
//
// request channel (valid/ready): command 0 loads entry_index with start frame,
//   pitch and rest flag; command 1 searches for search_frame between the
//   first_index and last_index registers. One transaction per item.
// result channel (valid/ready): one transaction per search carrying status
//   (0 pitch, 1 rest, 2 not found) and pitch; loads give no result.
// Config port: cfg_we writes cfg_data into register cfg_index (0 first_index,
//   1 last_index); other indexes are ignored. Write only while idle.
// Sequencing: a load is written to the table while the block stays idle and ready.
//   A search is accepted, then each probe puts the address out and then does the
//   registered RAM read and compare, and a closing step runs when the bounds meet.
//   The loop through the RAM's registered read port sets the pace of each probe;
//   no new request is taken until the search ends.
// The result sits in an output register; a stalled receiver holds it, and a
//   following search finishes its probes and waits only for that register.
// Reset clears the sequencer, the config registers and the result valid; the
//   table is not cleared and entries are undefined until loaded.
`default_nettype none

module note_interval_search #(
    parameter int NOTE_DEPTH = nis_pkg::NOTE_DEPTH_DEFAULT,
    parameter int FRAME_BITS = nis_pkg::FRAME_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [nis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [nis_pkg::INDEX_BITS-1:0]      cfg_data,
    nis_req_if.sink                                  request,
    nis_rsp_if.source                                result
);
    import nis_pkg::*;

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int WW = FRAME_BITS + 8;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [WW-1:0] mem_rdata_a;
    logic [WW-1:0] mem_rdata_b;

    nis_search_ctrl #(
        .NOTE_DEPTH (NOTE_DEPTH),
        .FRAME_BITS (FRAME_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .request     (request),
        .result      (result),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    nis_note_mem #(
        .DEPTH (NOTE_DEPTH),
        .WIDTH (WW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule

`default_nettype wire
